// ===== hdl/assert_macros.svh =====
// assertion macros for the deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hdl/ecfd_pkg.sv =====
package ecfd_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte FRAME_MARK  = 8'hFF;
    localparam t_byte ESCAPE_MARK = 8'hFE;

    typedef struct packed {
        logic  start;
        logic  empty;
        t_byte channel;
    } t_emit_req;

endpackage

// ===== hdl/ecfd_ram.sv =====
module ecfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ecfd_emit.sv =====
`include "assert_macros.svh"

module ecfd_emit
    import ecfd_pkg::*;
#(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_emit_req         i_req,
    input  logic [ADDR_W-1:0] i_fill,
    output logic [ADDR_W-1:0] o_raddr,
    input  t_byte             i_rdata,
    output logic              o_busy,
    output logic              o_strobe,
    output t_byte             o_data_byte,
    output t_byte             o_channel_id,
    output logic              o_last_of_packet,
    output logic              o_empty_packet
);

    logic              r_active;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last;
    t_byte             r_chan;
    logic              r_out_valid;
    logic              r_out_last;
    logic              r_out_empty;
    t_byte             r_out_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (r_active) begin
                r_out_valid <= 1'b1;
                r_out_last  <= (r_idx == r_last);
                r_out_empty <= 1'b0;
                r_out_chan  <= r_chan;
                r_idx       <= r_idx + 1'b1;
                if (r_idx == r_last) begin
                    r_active <= 1'b0;
                end
            end else if (i_req.start) begin
                if (i_req.empty) begin
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b1;
                    r_out_empty <= 1'b1;
                    r_out_chan  <= i_req.channel;
                end else begin
                    r_active <= 1'b1;
                    r_idx    <= '0;
                    r_last   <= i_fill - 1'b1;
                    r_chan   <= i_req.channel;
                end
            end
        end
    end

    assign o_raddr          = r_idx;
    assign o_busy           = r_active;
    assign o_strobe         = r_out_valid;
    assign o_data_byte      = r_out_empty ? '0 : i_rdata;
    assign o_channel_id     = r_out_chan;
    assign o_last_of_packet = r_out_last;
    assign o_empty_packet   = r_out_empty;

    `ASSERT_CLK(a_empty_is_last, i_clk, i_rst_n, (r_out_valid && r_out_empty) |-> r_out_last, "empty beat without last")
    `ASSERT_CLK(a_no_req_when_active, i_clk, i_rst_n, r_active |-> !i_req.start, "request while draining")
    `ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n, r_active && (r_idx == r_last), !r_active && r_out_valid && r_out_last, "drain did not end on last")

endmodule

// ===== hdl/escaped_channel_frame_deframer.sv =====
// escaped channel frame deframer
// input: one received byte per beat on i_rx_byte, taken when start is high and
// busy is low. 0xFF ends a frame and arms channel capture, 0xFE escapes the
// next byte, other bytes of an open packet are written to the store at the fill count.
// output: one beat per payload byte, marked by o_strobe for one cycle, with
// channel, last mark and empty mark; the receiver cannot stall it.
// throughput: payload and control bytes are taken one per cycle while busy is
// low. a frame end with n buffered bytes keeps busy high while the emitter
// reads the n entries from the store one entry per cycle through its single
// read port; an empty packet does not raise busy.
// output timing: a taken frame end byte sets the emitter's active flag, and
// the first beat of a packet then leaves its output register, the rest one per
// cycle; an empty packet beat shows in the cycle after the frame end byte.
// reset: synchronous active low; clears the control state, no packet is open
// and the store contents are left as they are.
module escaped_channel_frame_deframer
    import ecfd_pkg::*;
#(
    parameter int PACKET_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_rx_byte,
    output logic       o_strobe,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_channel_id,
    output logic       o_last_of_packet,
    output logic       o_empty_packet
);

    localparam int AW = $clog2(PACKET_BYTES);
    localparam logic [AW-1:0] FILL_MAX = AW'(PACKET_BYTES - 1);

    logic [AW-1:0] r_fill, n_fill;
    logic          r_in_pkt, n_in_pkt;
    logic          r_esc, n_esc;
    logic          r_await, n_await;
    t_byte         r_chan, n_chan;

    logic          accept;
    logic          we;
    t_emit_req     req;
    logic [AW-1:0] raddr;
    t_byte         rdata;
    logic          emit_busy;

    assign accept = start && !busy;
    assign busy   = emit_busy;

    always_comb begin
        n_fill      = r_fill;
        n_in_pkt    = r_in_pkt;
        n_esc       = r_esc;
        n_await     = r_await;
        n_chan      = r_chan;
        we          = 1'b0;
        req.start   = 1'b0;
        req.empty   = (r_fill == '0);
        req.channel = r_chan;
        if (accept) begin
            if (r_await) begin
                if (i_rx_byte != FRAME_MARK) begin
                    n_esc    = 1'b0;
                    n_await  = 1'b0;
                    n_fill   = '0;
                    n_in_pkt = 1'b1;
                    n_chan   = i_rx_byte;
                end
            end else if (i_rx_byte == FRAME_MARK && !r_esc) begin
                req.start = r_in_pkt;
                n_await   = 1'b1;
            end else if (i_rx_byte == ESCAPE_MARK && !r_esc) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                if (r_in_pkt) begin
                    we     = 1'b1;
                    n_fill = (r_fill == FILL_MAX) ? '0 : r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_in_pkt <= 1'b0;
            r_esc    <= 1'b0;
            r_await  <= 1'b0;
            r_chan   <= '0;
        end else begin
            r_fill   <= n_fill;
            r_in_pkt <= n_in_pkt;
            r_esc    <= n_esc;
            r_await  <= n_await;
            r_chan   <= n_chan;
        end
    end

    ecfd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ecfd_emit #(
        .ADDR_W (AW)
    ) u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req),
        .i_fill           (r_fill),
        .o_raddr          (raddr),
        .i_rdata          (rdata),
        .o_busy           (emit_busy),
        .o_strobe         (o_strobe),
        .o_data_byte      (o_data_byte),
        .o_channel_id     (o_channel_id),
        .o_last_of_packet (o_last_of_packet),
        .o_empty_packet   (o_empty_packet)
    );

endmodule
